>>> rtl/prd_pkg.sv
// ----------------------------------------------------------------------------
// prd_pkg
// Shared types and constants of the phase residue detector.
// ----------------------------------------------------------------------------
`default_nettype none

package prd_pkg;

   localparam int DEFAULT_MAX_WIDTH  = 1024;
   localparam int DEFAULT_PHASE_BITS = 16;
   localparam int HEIGHT_LIMIT       = 1024;

   localparam int SAMPLE_BITS = 16;
   localparam int CSR_BITS    = 11;
   localparam int COORD_BITS  = 10;
   localparam int REQ_BYTES   = 2;
   localparam int RSP_BYTES   = 3;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      CHARGE_NONE     = 2'd0,
      CHARGE_POSITIVE = 2'd1,
      CHARGE_NEGATIVE = 2'd2
   } charge_type;

endpackage

`default_nettype wire

>>> rtl/prd_loop_sum.sv
// ----------------------------------------------------------------------------
// prd_loop_sum
// Sums the four wrapped differences around a 2x2 window and gives its charge.
// ----------------------------------------------------------------------------
`default_nettype none

module prd_loop_sum #(
   parameter int PHASE_BITS = prd_pkg::DEFAULT_PHASE_BITS
) (
   input  wire logic [PHASE_BITS-1:0] upper_left,
   input  wire logic [PHASE_BITS-1:0] upper_right,
   input  wire logic [PHASE_BITS-1:0] lower_left,
   input  wire logic [PHASE_BITS-1:0] lower_right,
   output prd_pkg::charge_type        charge
);
   import prd_pkg::*;

   localparam int DW   = PHASE_BITS + 2;
   localparam int SW   = PHASE_BITS + 3;
   localparam int HALF = 1 << (PHASE_BITS - 1);
   localparam int FULL = 1 << PHASE_BITS;

   function automatic logic signed [PHASE_BITS:0] wrap_diff(
      input logic [PHASE_BITS-1:0] a,
      input logic [PHASE_BITS-1:0] b
   );
      logic signed [DW-1:0] d;
      d = $signed({2'b00, a}) - $signed({2'b00, b});
      if (d > $signed(DW'(HALF))) begin
         d = d - $signed(DW'(FULL));
      end else if (d < -$signed(DW'(HALF))) begin
         d = d + $signed(DW'(FULL));
      end
      return $signed(d[PHASE_BITS:0]);
   endfunction

   logic signed [PHASE_BITS:0] d_right;
   logic signed [PHASE_BITS:0] d_down;
   logic signed [PHASE_BITS:0] d_left;
   logic signed [PHASE_BITS:0] d_up;
   logic signed [SW-1:0]       loop_sum;

   always_comb begin
      d_right  = wrap_diff(upper_right, upper_left);
      d_down   = wrap_diff(lower_right, upper_right);
      d_left   = wrap_diff(lower_left, lower_right);
      d_up     = wrap_diff(upper_left, lower_left);
      loop_sum = SW'(d_right) + SW'(d_down) + SW'(d_left) + SW'(d_up);
      if (loop_sum > 0) begin
         charge = CHARGE_POSITIVE;
      end else if (loop_sum < 0) begin
         charge = CHARGE_NEGATIVE;
      end else begin
         charge = CHARGE_NONE;
      end
   end

endmodule

`default_nettype wire

>>> rtl/phase_residue_detector.sv
// ----------------------------------------------------------------------------
// phase_residue_detector
// Streaming residue detector for a wrapped phase image in raster order.
// ----------------------------------------------------------------------------
// req: one phase sample per transfer, tdata = phase_sample, tuser =
//   frame_start (restarts the position at column 0, row 0).
// rsp: one transfer for each pixel that closes a 2x2 window (not in row 0 or
//   column 0); tdata = charge, window column, window row; tlast marks the
//   window that closes the frame.
// csr: write enable, index and data; image_width (0) and image_height (1).
// Throughput: one sample per cycle while rsp is not stalled. The line store
//   is a single memory, read and written at the accepted sample's column in
//   the same cycle. A sample and its line store read are registered in stage
//   one, then the loop sum goes into the output register.
// Reset clears the position counters, the left-pixel registers and the
//   pipeline; the line store is not cleared. While rsp is stalled the output
//   register holds, samples are taken into the middle stage until one that
//   closes a window waits there, and then req_tready drops until the result drains.
// ----------------------------------------------------------------------------
`default_nettype none

module phase_residue_detector #(
   parameter int MAX_WIDTH  = prd_pkg::DEFAULT_MAX_WIDTH,
   parameter int PHASE_BITS = prd_pkg::DEFAULT_PHASE_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [prd_pkg::REQ_BYTES*8-1:0]      req_tdata,  // phase_sample
   input  wire logic                                 req_tuser,  // frame_start
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // residue_charge[1:0], window_col[11:2], window_row[21:12], zero pad
   output logic [prd_pkg::RSP_BYTES*8-1:0]           rsp_tdata,
   output logic                                      rsp_tlast,  // frame_last
   input  wire logic                                 csr_we,
   input  wire logic                                 csr_index,
   input  wire logic [prd_pkg::CSR_BITS-1:0]         csr_wdata
);
   import prd_pkg::*;

   localparam int COLW      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROWW      = $clog2(HEIGHT_LIMIT);
   localparam int WLAST_RST = ((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024) - 1;
   localparam int HLAST_RST = HEIGHT_LIMIT - 1;
   localparam int RSP_PAD   = RSP_BYTES * 8 - 2 - 2 * COORD_BITS;

   // configuration
   logic [COLW-1:0] wlast_ff, wlast_in;
   logic [ROWW-1:0] hlast_ff, hlast_in;
   int              wval, hval;

   always_comb begin
      wval     = int'(csr_wdata);
      hval     = int'(csr_wdata);
      if (wval < 2) wval = 2;
      if (wval > MAX_WIDTH) wval = MAX_WIDTH;
      if (hval < 2) hval = 2;
      if (hval > HEIGHT_LIMIT) hval = HEIGHT_LIMIT;
      wlast_in = wlast_ff;
      hlast_in = hlast_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  wlast_in = COLW'(wval - 1);
            CSR_IMAGE_HEIGHT: hlast_in = ROWW'(hval - 1);
            default:          wlast_in = wlast_ff;
         endcase
      end
   end

   // position counters and stage one
   logic                  req_accept;
   logic [PHASE_BITS-1:0] sample;
   logic [COLW-1:0]       col_ff, col_in, col_sel;
   logic [ROWW-1:0]       row_ff, row_in, row_sel;
   logic                  col_end, row_end;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_produce_ff, s1_last_ff;
   logic [PHASE_BITS-1:0] s1_samp_ff;
   logic [COLW-1:0]       s1_col_ff;
   logic [ROWW-1:0]       s1_row_ff;
   logic                  s1_move;

   logic [PHASE_BITS-1:0] line_mem [MAX_WIDTH];
   logic [PHASE_BITS-1:0] line_rd_ff;
   logic [PHASE_BITS-1:0] left_current_ff, left_above_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_BYTES*8-1:0] rsp_data_ff;
   logic                  rsp_last_ff;
   charge_type            charge;

   assign sample     = PHASE_BITS'(req_tdata[SAMPLE_BITS-1:0]);
   assign req_accept = req_tvalid && req_tready;
   assign s1_move    = s1_valid_ff && (!s1_produce_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;

   always_comb begin
      col_sel = req_tuser ? '0 : col_ff;
      row_sel = req_tuser ? '0 : row_ff;
      col_end = (col_sel >= wlast_ff);
      row_end = (row_sel >= hlast_ff);
      col_in  = col_ff;
      row_in  = row_ff;
      if (req_accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : ROWW'(row_sel + 1'b1);
         end else begin
            col_in = COLW'(col_sel + 1'b1);
            row_in = row_sel;
         end
      end
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_move && s1_produce_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff        <= COLW'(WLAST_RST);
         hlast_ff        <= ROWW'(HLAST_RST);
         col_ff          <= '0;
         row_ff          <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         left_current_ff <= '0;
         left_above_ff   <= '0;
      end else begin
         wlast_ff     <= wlast_in;
         hlast_ff     <= hlast_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_move) begin
            left_above_ff   <= line_rd_ff;
            left_current_ff <= s1_samp_ff;
         end
      end
   end

   // line store: read-first, one access per accepted sample
   always_ff @(posedge clock) begin
      if (req_accept) begin
         line_rd_ff        <= line_mem[col_sel];
         line_mem[col_sel] <= sample;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_samp_ff    <= sample;
         s1_col_ff     <= col_sel;
         s1_row_ff     <= row_sel;
         s1_produce_ff <= (col_sel != '0) && (row_sel != '0);
         s1_last_ff    <= col_end && row_end;
      end
   end

   prd_loop_sum #(
      .PHASE_BITS (PHASE_BITS)
   ) u_loop_sum (
      .upper_left  (left_above_ff),
      .upper_right (line_rd_ff),
      .lower_left  (left_current_ff),
      .lower_right (s1_samp_ff),
      .charge      (charge)
   );

   always_ff @(posedge clock) begin
      if (s1_move && s1_produce_ff) begin
         rsp_data_ff <= {{RSP_PAD{1'b0}},
                         COORD_BITS'(ROWW'(s1_row_ff - 1'b1)),
                         COORD_BITS'(COLW'(s1_col_ff - 1'b1)),
                         charge};
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_no_stage_overrun : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |-> !req_accept)
      else $error("stage one overwritten while held");

   a_frame_start_col : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tuser) |=> (col_ff == COLW'(1)))
      else $error("frame start did not restart the column count");

   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_produce_ff))
      else $error("result raised without a window in stage one");

endmodule

`default_nettype wire
